// ----- rtl/core/jpms_pkg.sv -----
// Shared types, constants and arithmetic helpers for the joint plant model step.
// Used by jpms_ctrl, jpms_dp and joint_plant_model_step. Has no dependencies.
`default_nettype none
package jpms_pkg;

    localparam int NUM_JOINTS  = 16;
    localparam int JOINT_W     = 4;
    localparam int TS_W        = 20;
    localparam int Q_W         = 32;
    localparam int S_DATA_W    = 120;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 96;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_A_W     = 41;
    localparam int MUL_B_W     = 26;
    localparam int PROD_W      = 67;
    localparam int WIDE_W      = 68;
    localparam int DIV_W       = 53;
    localparam int DIV_CNT_W   = 6;
    localparam int DIV_STEPS   = 53;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_GAIN        = 3'd0,
        CFG_VEL_LIMIT         = 3'd1,
        CFG_POSITION_GAIN     = 3'd2,
        CFG_DAMPING           = 3'd3,
        CFG_FRICTION          = 3'd4,
        CFG_EFFORT_DEADZONE   = 3'd5,
        CFG_VELOCITY_DEADZONE = 3'd6
    } cfg_idx_t;

    // Update mode chosen when an item is loaded.
    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_KEEP,
        MODE_POS,
        MODE_VEL,
        MODE_EFF
    } mode_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_PG,
        OP_MUL_VTS,
        OP_MUL_AE,
        OP_MUL_VD,
        OP_MUL_ATS,
        OP_MUL_FTS,
        OP_MUL_V1F,
        OP_MUL_V2TS,
        OP_SET_A,
        OP_SET_T,
        OP_SET_V1,
        OP_SET_F,
        OP_SET_V2,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WB
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_P_MUL,
        S_P_SETUP,
        S_P_DIV,
        S_V_MUL,
        S_E_MUL_A,
        S_E_SET_A,
        S_E_MUL_D,
        S_E_SET_T,
        S_E_MUL_ATS,
        S_E_SET_V1,
        S_E_MUL_F,
        S_E_SET_F,
        S_E_MUL_V1F,
        S_E_SET_V2,
        S_E_MUL_V2TS,
        S_WB
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  out_full;
    } status_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        begin
            hi = WIDE_W'(64'sh7FFF_FFFF);
            lo = -WIDE_W'(64'sh8000_0000);
            if (x > hi) begin
                sat32 = Q_W'(hi);
            end else if (x < lo) begin
                sat32 = Q_W'(lo);
            end else begin
                sat32 = Q_W'(x);
            end
        end
    endfunction

    // Add half an LSB and shift right arithmetically (ties toward +inf).
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] x,
        input int unsigned              s
    );
        logic signed [PROD_W-1:0] half;
        begin
            half = PROD_W'(1) <<< (s - 1);
            rnd_shift = (x + half) >>> s;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/jpms_ctrl.sv -----
// Controller state machine for the joint plant model step.
// Sequences the datapath operations; depends on jpms_pkg.
`default_nettype none
module jpms_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  jpms_pkg::status_t     status,
    output jpms_pkg::cmd_t        cmd
);
    import jpms_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // State and step counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // No beat is taken while reset is held.
                s_tready = aresetn;
                if (aresetn && s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.mode)
                    MODE_POS: state_next = S_P_MUL;
                    MODE_VEL: state_next = S_V_MUL;
                    MODE_EFF: state_next = S_E_MUL_A;
                    default:  state_next = S_WB;
                endcase
            end
            S_P_MUL: begin
                cmd.op     = OP_MUL_PG;
                state_next = S_P_SETUP;
            end
            S_P_SETUP: begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_P_DIV;
            end
            S_P_DIV: begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_WB;
                end
            end
            S_V_MUL: begin
                cmd.op     = OP_MUL_VTS;
                state_next = S_WB;
            end
            S_E_MUL_A: begin
                cmd.op     = OP_MUL_AE;
                state_next = S_E_SET_A;
            end
            S_E_SET_A: begin
                cmd.op     = OP_SET_A;
                state_next = S_E_MUL_D;
            end
            S_E_MUL_D: begin
                cmd.op     = OP_MUL_VD;
                state_next = S_E_SET_T;
            end
            S_E_SET_T: begin
                cmd.op     = OP_SET_T;
                state_next = S_E_MUL_ATS;
            end
            S_E_MUL_ATS: begin
                cmd.op     = OP_MUL_ATS;
                state_next = S_E_SET_V1;
            end
            S_E_SET_V1: begin
                cmd.op     = OP_SET_V1;
                state_next = S_E_MUL_F;
            end
            S_E_MUL_F: begin
                cmd.op     = OP_MUL_FTS;
                state_next = S_E_SET_F;
            end
            S_E_SET_F: begin
                cmd.op     = OP_SET_F;
                state_next = S_E_MUL_V1F;
            end
            S_E_MUL_V1F: begin
                cmd.op     = OP_MUL_V1F;
                state_next = S_E_SET_V2;
            end
            S_E_SET_V2: begin
                cmd.op     = OP_SET_V2;
                state_next = S_E_MUL_V2TS;
            end
            S_E_MUL_V2TS: begin
                cmd.op     = OP_MUL_V2TS;
                state_next = S_WB;
            end
            S_WB: begin
                // Hold the result until the output register is free.
                if (!status.out_full) begin
                    cmd.op     = OP_WB;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/jpms_dp.sv -----
// Datapath for the joint plant model step: joint stores, configuration,
// shared multiplier, restoring divider and output register. Depends on jpms_pkg.
`default_nettype none
module jpms_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [jpms_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic [jpms_pkg::S_USER_W-1:0]      s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [jpms_pkg::M_DATA_W-1:0]           m_tdata,
    input  wire logic                               cfg_valid,
    input  wire logic [jpms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jpms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  jpms_pkg::cmd_t                          cmd,
    output jpms_pkg::status_t                       status
);
    import jpms_pkg::*;

    // Configuration. The effort deadzone is accepted but has no effect.
    logic [23:0] ape_reg;
    logic [30:0] maxv_reg;
    logic [16:0] gain_reg;
    logic [16:0] damp_reg;
    logic [23:0] fric_reg;
    logic [30:0] vdz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ape_reg  <= 24'd65536;
            maxv_reg <= 31'd655360;
            gain_reg <= 17'd6554;
            damp_reg <= 17'd65536;
            fric_reg <= '0;
            vdz_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACCEL_GAIN:        ape_reg  <= cfg_data[23:0];
                CFG_VEL_LIMIT:         maxv_reg <= cfg_data[30:0];
                CFG_POSITION_GAIN:     gain_reg <= cfg_data[16:0];
                CFG_DAMPING:           damp_reg <= cfg_data[16:0];
                CFG_FRICTION:          fric_reg <= cfg_data[23:0];
                CFG_VELOCITY_DEADZONE: vdz_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Input fields of the beat being loaded.
    logic [JOINT_W-1:0]     in_j;
    logic [TS_W-1:0]        in_ts;
    logic                   in_j_ok;
    mode_t                  in_mode;

    assign in_j    = s_tdata[3:0];
    assign in_ts   = s_tdata[23:4];
    assign in_j_ok = (32'(in_j) < NUM_JOINTS);

    always_comb begin
        priority if (!in_j_ok) begin
            in_mode = MODE_ZERO;
        end else if (in_ts == '0) begin
            in_mode = MODE_KEEP;
        end else if (s_tuser[0]) begin
            in_mode = MODE_POS;
        end else if (s_tuser[1]) begin
            in_mode = MODE_VEL;
        end else if (s_tuser[2]) begin
            in_mode = MODE_EFF;
        end else begin
            in_mode = MODE_KEEP;
        end
    end

    // Latched item and working registers.
    mode_t                      mode_reg;
    logic [JOINT_W-1:0]         j_reg;
    logic [TS_W-1:0]            ts_reg;
    logic signed [Q_W-1:0]      pcmd_reg, vcmd_reg, ecmd_reg;
    logic signed [Q_W-1:0]      p_reg, v_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [40:0]         a_reg;
    logic signed [33:0]         t_reg;
    logic signed [39:0]         v1_reg;
    logic signed [25:0]         f_reg;
    logic signed [Q_W-1:0]      v2_reg;
    logic signed [Q_W-1:0]      np_reg;
    logic                       neg_reg;
    logic [DIV_W-1:0]           quo_reg;
    logic [TS_W:0]              rem_reg;

    logic signed [Q_W-1:0]      pos_store_reg [NUM_JOINTS];
    logic signed [Q_W-1:0]      vel_store_reg [NUM_JOINTS];
    logic signed [Q_W-1:0]      eff_store_reg [NUM_JOINTS];

    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;

    // Shared multiplier operand selection.
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod_full;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_PG: begin
                mul_a = MUL_A_W'(33'(pcmd_reg) - 33'(p_reg));
                mul_b = $signed(MUL_B_W'(gain_reg));
            end
            OP_MUL_VTS: begin
                mul_a = MUL_A_W'(vcmd_reg);
                mul_b = $signed(MUL_B_W'(ts_reg));
            end
            OP_MUL_AE: begin
                mul_a = MUL_A_W'(ecmd_reg);
                mul_b = $signed(MUL_B_W'(ape_reg));
            end
            OP_MUL_VD: begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = $signed(MUL_B_W'(damp_reg));
            end
            OP_MUL_ATS: begin
                mul_a = a_reg;
                mul_b = $signed(MUL_B_W'(ts_reg));
            end
            OP_MUL_FTS: begin
                mul_a = $signed(MUL_A_W'(fric_reg));
                mul_b = $signed(MUL_B_W'(ts_reg));
            end
            OP_MUL_V1F: begin
                mul_a = MUL_A_W'(v1_reg);
                mul_b = f_reg;
            end
            OP_MUL_V2TS: begin
                mul_a = MUL_A_W'(v2_reg);
                mul_b = $signed(MUL_B_W'(ts_reg));
            end
            default: ;
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Step results computed from the registered product.
    logic signed [PROD_W-1:0]   r16, r20;
    logic signed [WIDE_W-1:0]   v1_sum;
    logic signed [WIDE_W-1:0]   v1_lim;
    logic signed [39:0]         v1_c;
    logic signed [PROD_W-1:0]   maxv_s;
    logic signed [Q_W-1:0]      v2_c;
    logic [Q_W-1:0]             v2_mag;
    logic signed [Q_W-1:0]      np_c;
    logic signed [32:0]         dp_c;
    logic [32:0]                dp_mag;
    logic signed [Q_W-1:0]      np_int;

    assign r16 = rnd_shift(prod_reg, 16);
    assign r20 = rnd_shift(prod_reg, 20);

    always_comb begin
        // Velocity after damping and acceleration, limited before friction.
        v1_sum = WIDE_W'(t_reg) + WIDE_W'(r20);
        v1_lim = WIDE_W'(64'sh40_0000_0000);
        if (v1_sum > v1_lim) begin
            v1_c = 40'(v1_lim);
        end else if (v1_sum < -v1_lim) begin
            v1_c = 40'(-v1_lim);
        end else begin
            v1_c = 40'(v1_sum);
        end

        // Friction-scaled velocity, clamp and speed deadzone.
        maxv_s = $signed(PROD_W'(maxv_reg));
        if (r16 > maxv_s) begin
            v2_c = Q_W'(maxv_s);
        end else if (r16 < -maxv_s) begin
            v2_c = Q_W'(-maxv_s);
        end else begin
            v2_c = Q_W'(r16);
        end
        v2_mag = v2_c[Q_W-1] ? Q_W'(-v2_c) : Q_W'(v2_c);
        if (v2_mag < Q_W'(vdz_reg)) begin
            v2_c = '0;
        end

        // Low-pass position step and its change for the divider.
        np_c   = sat32(WIDE_W'(p_reg) + WIDE_W'(r16));
        dp_c   = 33'(np_c) - 33'(p_reg);
        dp_mag = dp_c[32] ? 33'(-dp_c) : 33'(dp_c);

        // Position integrated from the last product, for writeback.
        np_int = sat32(WIDE_W'(p_reg) + WIDE_W'(r20));
    end

    // One restoring divider step.
    logic [TS_W:0]   rem_sh;
    logic            q_bit;
    logic [TS_W:0]   rem_new;

    always_comb begin
        rem_sh  = {rem_reg[TS_W-1:0], quo_reg[DIV_W-1]};
        q_bit   = (rem_sh >= (TS_W+1)'(ts_reg));
        rem_new = q_bit ? (rem_sh - (TS_W+1)'(ts_reg)) : rem_sh;
    end

    // Signed, saturated quotient.
    logic signed [WIDE_W-1:0]   q_wide;
    logic signed [Q_W-1:0]      q_sat;

    assign q_wide = neg_reg ? -$signed(WIDE_W'(quo_reg)) : $signed(WIDE_W'(quo_reg));
    assign q_sat  = sat32(q_wide);

    // Working registers.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                j_reg    <= in_j;
                ts_reg   <= in_ts;
                pcmd_reg <= s_tdata[55:24];
                vcmd_reg <= s_tdata[87:56];
                ecmd_reg <= s_tdata[119:88];
                p_reg    <= pos_store_reg[in_j];
                v_reg    <= vel_store_reg[in_j];
            end
            OP_MUL_PG, OP_MUL_VTS, OP_MUL_AE, OP_MUL_VD, OP_MUL_ATS,
            OP_MUL_FTS, OP_MUL_V1F, OP_MUL_V2TS: begin
                prod_reg <= prod_full;
            end
            OP_SET_A:  a_reg  <= 41'(r16);
            OP_SET_T:  t_reg  <= 34'(r16);
            OP_SET_V1: v1_reg <= v1_c;
            OP_SET_F:  f_reg  <= 26'sd65536 - 26'(r20);
            OP_SET_V2: v2_reg <= v2_c;
            OP_DIV_INIT: begin
                np_reg  <= np_c;
                neg_reg <= dp_c[32];
                quo_reg <= {dp_mag, {TS_W{1'b0}}};
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            end
            default: ;
        endcase
    end

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_KEEP;
        end else if (cmd.op == OP_LOAD) begin
            mode_reg <= in_mode;
        end
    end

    // Writeback values by mode.
    logic signed [Q_W-1:0] wb_pos, wb_vel, wb_eff;
    logic                  wb_store;

    always_comb begin
        wb_store = 1'b1;
        wb_pos   = pos_store_reg[j_reg];
        wb_vel   = vel_store_reg[j_reg];
        wb_eff   = eff_store_reg[j_reg];
        unique case (mode_reg)
            MODE_ZERO: begin
                wb_store = 1'b0;
                wb_pos   = '0;
                wb_vel   = '0;
                wb_eff   = '0;
            end
            MODE_KEEP: wb_store = 1'b0;
            MODE_POS: begin
                wb_pos = np_reg;
                wb_vel = q_sat;
                wb_eff = '0;
            end
            MODE_VEL: begin
                wb_pos = np_int;
                wb_vel = vcmd_reg;
                wb_eff = '0;
            end
            MODE_EFF: begin
                wb_pos = np_int;
                wb_vel = v2_reg;
                wb_eff = ecmd_reg;
            end
            default: wb_store = 1'b0;
        endcase
    end

    // Joint stores, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_JOINTS; i++) begin
                pos_store_reg[i] <= '0;
                vel_store_reg[i] <= '0;
                eff_store_reg[i] <= '0;
            end
        end else if (cmd.op == OP_WB && wb_store) begin
            pos_store_reg[j_reg] <= wb_pos;
            vel_store_reg[j_reg] <= wb_vel;
            eff_store_reg[j_reg] <= wb_eff;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_WB) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WB) begin
            m_tdata_reg <= {wb_eff, wb_vel, wb_pos};
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.mode     = mode_reg;
    assign status.out_full = m_tvalid_reg;

endmodule
`default_nettype wire

// ----- rtl/core/joint_plant_model_step.sv -----
// Top level of the joint plant model step: controller plus datapath.
// An item is loaded, dispatched by mode, computed and written back; position
// mode multiplies then runs the 53-step restoring divider, velocity mode
// multiplies once, effort chains products, no update goes to writeback.
// One item at a time; writeback waits while the previous output is unread.
// Reset: aresetn sync active low; resets state, config, stores, output valid.
`default_nettype none
module joint_plant_model_step (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // joint_index[3:0], time_step[23:4], position_cmd[55:24],
    // velocity_cmd[87:56], effort_cmd[119:88]
    input  wire logic [jpms_pkg::S_DATA_W-1:0]      s_tdata,
    // position_cmd_valid[0], velocity_cmd_valid[1], effort_cmd_valid[2]
    input  wire logic [jpms_pkg::S_USER_W-1:0]      s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // joint_position[31:0], joint_velocity[63:32], joint_effort[95:64]
    output logic [jpms_pkg::M_DATA_W-1:0]           m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [jpms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [jpms_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jpms_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are taken in any cycle outside reset.
    assign cfg_ready = aresetn;

    jpms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jpms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire
